// File: hdl/image_gradient_3x3_unit_assert.svh
// Assertion macros for the gradient unit; compiled out under SYNTHESIS.
`ifndef IMAGE_GRADIENT_3X3_UNIT_ASSERT_SVH
`define IMAGE_GRADIENT_3X3_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define IG3_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");
// next-cycle implication
`define IG3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: ante implies cons next cycle");
`else
`define IG3_ASSERT_NOW(label, ante, cons)
`define IG3_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/ig3_pkg.sv
package ig3_pkg;

  localparam int PIX_W      = 16;
  localparam int GRAD_W     = 19;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 16;
  localparam int IMG_W_W    = 12;
  localparam int IMG_H_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int MIN_DIM    = 3;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = IMG_W_W'(2048);
  localparam logic [IMG_H_W-1:0] IMG_H_RST = IMG_H_W'(2048);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

  // one window column: top, middle, current row
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t cur;
  } win_col_t;

  function automatic grad_t pix_ext(input pix_t p);
    return grad_t'({{(GRAD_W - PIX_W){1'b0}}, p});
  endfunction

endpackage

// File: hdl/ig3_ram.sv
module ig3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/image_gradient_3x3_unit.sv
// A request passes stage 1 and the output register. Throughput: 1 pixel per cycle
// unless out_stall holds, set by the line RAM (one read, one write a cycle).
// Border pixels give no output; out_last marks the final gradient of a frame.
// Reset (rst_n low, synchronous): counters to zero, width/height to 2048,
// pipeline empty. Line RAM is not cleared; rows fill in as the frame streams.
`include "image_gradient_3x3_unit_assert.svh"

module image_gradient_3x3_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ig3_pkg::PIX_W-1:0]           in_pixel,
  // gradient output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ig3_pkg::GRAD_W-1:0]   out_grad_x,
  output logic signed [ig3_pkg::GRAD_W-1:0]   out_grad_y,
  output logic [ig3_pkg::COL_W-1:0]           out_col,
  output logic [ig3_pkg::ROW_W-1:0]           out_row,
  output logic                                out_last,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ig3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ig3_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Column counter addresses the line RAM directly.
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  // Width for comparing column+1 against the effective width.
  localparam int EW = (CW + 1 > ig3_pkg::IMG_W_W) ? CW + 1 : ig3_pkg::IMG_W_W;
  // Width for forming column-1.
  localparam int XW = (CW > ig3_pkg::COL_W) ? CW : ig3_pkg::COL_W;
  localparam int HW = ig3_pkg::IMG_H_W + 1;
  localparam int RW = 2 * ig3_pkg::PIX_W;

  // ---------------------------------------------------------------------
  // Configuration registers. Always ready; user writes only when idle, unenforced.
  // ---------------------------------------------------------------------
  logic [ig3_pkg::IMG_W_W-1:0] img_w_r;
  logic [ig3_pkg::IMG_H_W-1:0] img_h_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= ig3_pkg::IMG_W_RST;
      img_h_r <= ig3_pkg::IMG_H_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (ig3_pkg::cfg_reg_t'(cfg_index))
        ig3_pkg::REG_IMAGE_WIDTH:  img_w_r <= cfg_data[ig3_pkg::IMG_W_W-1:0];
        ig3_pkg::REG_IMAGE_HEIGHT: img_h_r <= cfg_data[ig3_pkg::IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: width clamped to [3, MAX_WIDTH], height to >= 3.
  logic [EW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    eff_w = EW'(img_w_r);
    if (eff_w < EW'(ig3_pkg::MIN_DIM)) begin
      eff_w = EW'(ig3_pkg::MIN_DIM);
    end else if (eff_w > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end
    eff_h = HW'(img_h_r);
    if (eff_h < HW'(ig3_pkg::MIN_DIM)) begin
      eff_h = HW'(ig3_pkg::MIN_DIM);
    end
  end

  // ---------------------------------------------------------------------
  // Handshake. Stage 1 holds the accepted pixel while the line RAM read
  // returns; the output register holds a finished gradient. Stage 1 drains
  // whenever the output register is free or being taken this cycle.
  // ---------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, s1_move, in_acc;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Frame position counters, advanced on every accepted request.
  // ---------------------------------------------------------------------
  logic [CW-1:0]              col_cnt_r, col_cnt_nxt;
  logic [ig3_pkg::ROW_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic [EW-1:0]              col_inc;
  logic [HW-1:0]              row_inc;
  logic                       end_row, end_frame, emit;

  always_comb begin
    col_inc   = EW'(col_cnt_r) + EW'(1);
    row_inc   = HW'(row_cnt_r) + HW'(1);
    end_row   = (col_inc >= eff_w);
    end_frame = end_row && (row_inc >= eff_h);
    // interior once two columns and two rows are behind us
    emit      = (EW'(col_cnt_r) >= EW'(2)) && (row_cnt_r >= ig3_pkg::ROW_W'(2));

    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_acc) begin
      if (end_frame) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = '0;
      end else if (end_row) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_inc[ig3_pkg::ROW_W-1:0];
      end else begin
        col_cnt_nxt = col_inc[CW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1 registers (pixel and its position, RAM read in flight).
  // ---------------------------------------------------------------------
  ig3_pkg::pix_t              s1_pix_r;
  logic [CW-1:0]              s1_col_r;
  logic [ig3_pkg::ROW_W-1:0]  s1_row_r;
  logic                       s1_emit_r;
  logic                       s1_last_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_pixel;
      s1_col_r  <= col_cnt_r;
      s1_row_r  <= row_cnt_r;
      s1_emit_r <= emit;
      s1_last_r <= end_frame;
    end
  end

  // ---------------------------------------------------------------------
  // Line RAM: each entry packs {two rows up, one row up} for a column.
  // Read at accept, written back shifted when stage 1 drains. The read
  // and write columns of neighboring requests always differ (width >= 3).
  // ---------------------------------------------------------------------
  logic [RW-1:0] line_rd;
  logic [RW-1:0] line_wr;

  assign line_wr = {line_rd[ig3_pkg::PIX_W-1:0], s1_pix_r};

  ig3_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_col_r),
    .wdata (line_wr),
    .re    (in_acc),
    .raddr (col_cnt_r),
    .rdata (line_rd)
  );

  // ---------------------------------------------------------------------
  // Window: two stored columns plus the incoming one. Stored columns need
  // no reset; a gradient only uses columns of the current row.
  // ---------------------------------------------------------------------
  ig3_pkg::win_col_t win_c1_r, win_c2_r, win_new;

  assign win_new.top = line_rd[RW-1:ig3_pkg::PIX_W];
  assign win_new.mid = line_rd[ig3_pkg::PIX_W-1:0];
  assign win_new.cur = s1_pix_r;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      win_c1_r <= win_c2_r;
      win_c2_r <= win_new;
    end
  end

  // Gradients over the shifted window: old c1 is the left column, old c2
  // the center column and win_new the right column. Four times the scaled
  // gradient, so every term is an exact integer.
  ig3_pkg::grad_t grad_x, grad_y;
  logic [XW-1:0]  col_m1;
  logic [ig3_pkg::ROW_W-1:0] row_m1;

  always_comb begin
    grad_x = ig3_pkg::pix_ext(win_new.top) - ig3_pkg::pix_ext(win_c2_r.top)
           + ((ig3_pkg::pix_ext(win_new.mid) - ig3_pkg::pix_ext(win_c2_r.mid)) <<< 1)
           + ig3_pkg::pix_ext(win_new.cur) - ig3_pkg::pix_ext(win_c2_r.cur);
    grad_y = ig3_pkg::pix_ext(win_c1_r.cur) - ig3_pkg::pix_ext(win_c1_r.mid)
           + ((ig3_pkg::pix_ext(win_c2_r.cur) - ig3_pkg::pix_ext(win_c2_r.mid)) <<< 1)
           + ig3_pkg::pix_ext(win_new.cur) - ig3_pkg::pix_ext(win_new.mid);
    col_m1 = XW'(s1_col_r) - XW'(1);
    row_m1 = s1_row_r - ig3_pkg::ROW_W'(1);
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  ig3_pkg::grad_t            out_grad_x_r, out_grad_y_r;
  logic [ig3_pkg::COL_W-1:0] out_col_r;
  logic [ig3_pkg::ROW_W-1:0] out_row_r;
  logic                      out_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_move && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_emit_r) begin
      out_grad_x_r <= grad_x;
      out_grad_y_r <= grad_y;
      out_col_r    <= col_m1[ig3_pkg::COL_W-1:0];
      out_row_r    <= row_m1;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_grad_x = out_grad_x_r;
  assign out_grad_y = out_grad_y_r;
  assign out_col    = out_col_r;
  assign out_row    = out_row_r;
  assign out_last   = out_last_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // a new request can only land in stage 1 if its occupant leaves
  `IG3_ASSERT_NOW(a_s1_no_overwrite, in_acc && s1_valid_r, s1_move)
  // an interior pixel leaving stage 1 always shows up on the output
  `IG3_ASSERT_NEXT(a_emit_reaches_out, s1_move && s1_emit_r, out_valid_r)
  // counters wrap to the frame origin after the last pixel
  `IG3_ASSERT_NEXT(a_frame_wrap, in_acc && end_frame, col_cnt_r == '0 && row_cnt_r == '0)

endmodule

// File: dv/tb_image_gradient_3x3_unit.sv
module tb_image_gradient_3x3_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W          = 2048;
  localparam int OPEN_W         = 40;    // widest random frame
  localparam int RST_CYCLES     = 10;
  localparam int DRAIN_CYCLES   = 8;     // lets stage 1 and the output register drain; margin for border pixels
  localparam int HOLD_CYCLES    = 400;   // long output hold-off, fills the pipeline
  localparam int QUIET_LIMIT    = 5000;  // cycles with no request moving at all
  localparam int MAX_REPORTS    = 10;
  localparam int RAND_PER_PHASE = 250;

  // one gradient as the block should report it
  typedef struct {
    ig3_pkg::grad_t            gx;
    ig3_pkg::grad_t            gy;
    logic [ig3_pkg::COL_W-1:0] col;
    logic [ig3_pkg::ROW_W-1:0] row;
    logic                      last;
  } grad_rec_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  ig3_pkg::pix_t                  in_pixel  = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  ig3_pkg::grad_t                 out_grad_x;
  ig3_pkg::grad_t                 out_grad_y;
  logic [ig3_pkg::COL_W-1:0]      out_col;
  logic [ig3_pkg::ROW_W-1:0]      out_row;
  logic                           out_last;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ig3_pkg::CFG_IDX_W-1:0]  cfg_index = ig3_pkg::REG_IMAGE_WIDTH;
  logic [ig3_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  image_gradient_3x3_unit #(
    .MAX_WIDTH(MAX_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_grad_x(out_grad_x),
    .out_grad_y(out_grad_y),
    .out_col   (out_col),
    .out_row   (out_row),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Stimulus control shared between the sequence and the clocked processes
  // ---------------------------------------------------------------------------
  ig3_pkg::pix_t pixel_q [$];          // pixels waiting for the driver
  grad_rec_t     expected_grads [$];   // predicted gradients, oldest first
  int unsigned   pix_sent    = 0;      // pixels handed to pixel_q
  int unsigned   pix_taken   = 0;      // pixel requests the block accepted
  int unsigned   mismatches  = 0;
  int unsigned   in_idle_pct   = 0;
  int unsigned   out_stall_pct = 0;
  logic          hold_req    = 1'b0;   // asks the stall process for one long hold-off
  int unsigned   hold_cnt    = 0;
  int unsigned   quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Gradient predictor: line stores, 3x3 window, frame counters, registers
  // ---------------------------------------------------------------------------
  ig3_pkg::pix_t               up1_line [MAX_W] = '{default: '0};  // row above
  ig3_pkg::pix_t               up2_line [MAX_W] = '{default: '0};  // two rows above
  ig3_pkg::win_col_t           win [3] = '{default: '0};           // [0] oldest column
  int unsigned                 col_cnt = 0;
  int unsigned                 row_cnt = 0;
  logic [ig3_pkg::IMG_W_W-1:0] width_reg  = ig3_pkg::IMG_W_RST;
  logic [ig3_pkg::IMG_H_W-1:0] height_reg = ig3_pkg::IMG_H_RST;

  // out-of-range widths clamp to 3..MAX_W, heights below 3 act as 3
  function automatic int unsigned eff_width();
    if (width_reg < ig3_pkg::MIN_DIM) return ig3_pkg::MIN_DIM;
    if (width_reg > MAX_W) return MAX_W;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < ig3_pkg::MIN_DIM) return ig3_pkg::MIN_DIM;
    return 32'(height_reg);
  endfunction

  function automatic void predict_gradient(input ig3_pkg::pix_t p);
    int unsigned       w, h, x, y, idx;
    int                gx, gy;
    logic              end_row, end_frame;
    ig3_pkg::win_col_t newest;
    grad_rec_t         g;
    w   = eff_width();
    h   = eff_height();
    x   = col_cnt;
    y   = row_cnt;
    idx = x % MAX_W;
    newest.top = up2_line[idx];
    newest.mid = up1_line[idx];
    newest.cur = p;
    up2_line[idx] = up1_line[idx];
    up1_line[idx] = p;
    win[0] = win[1];
    win[1] = win[2];
    win[2] = newest;
    end_row   = (x + 1 >= w);
    end_frame = end_row && (y + 1 >= h);
    // window centered on (x-1, y-1) once two rows and two columns are in
    if (x >= 2 && y >= 2) begin
      gx = int'(win[2].top) - int'(win[1].top)
         + 2 * (int'(win[2].mid) - int'(win[1].mid))
         + int'(win[2].cur) - int'(win[1].cur);
      gy = int'(win[0].cur) - int'(win[0].mid)
         + 2 * (int'(win[1].cur) - int'(win[1].mid))
         + int'(win[2].cur) - int'(win[2].mid);
      g.gx   = ig3_pkg::grad_t'(gx);
      g.gy   = ig3_pkg::grad_t'(gy);
      g.col  = ig3_pkg::COL_W'(x - 1);
      g.row  = ig3_pkg::ROW_W'(y - 1);
      g.last = end_frame;
      expected_grads.push_back(g);
    end
    if (end_frame) begin
      col_cnt = 0;
      row_cnt = 0;
    end else if (end_row) begin
      col_cnt = 0;
      row_cnt = (y + 1) & ((1 << ig3_pkg::ROW_W) - 1);
    end else begin
      col_cnt = x + 1;
    end
  endfunction

  function automatic void check_gradient();
    grad_rec_t e;
    if (expected_grads.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected gradient: col %0d row %0d gx %0d gy %0d",
                 out_col, out_row, out_grad_x, out_grad_y);
      return;
    end
    e = expected_grads.pop_front();
    if (out_grad_x !== e.gx || out_grad_y !== e.gy || out_col !== e.col ||
        out_row !== e.row || out_last !== e.last) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("gradient mismatch: exp gx %0d gy %0d col %0d row %0d last %0b",
                 e.gx, e.gy, e.col, e.row, e.last,
                 " / got gx %0d gy %0d col %0d row %0d last %0b",
                 out_grad_x, out_grad_y, out_col, out_row, out_last);
    end
  endfunction

  // pixels left until the frame wraps, from the current counters and registers
  function automatic int unsigned frame_rest();
    int unsigned w, h, x, y, n;
    w = eff_width();
    h = eff_height();
    x = col_cnt;
    y = row_cnt;
    n = 0;
    forever begin
      n++;
      if (x + 1 >= w) begin
        if (y + 1 >= h) return n;
        x = 0;
        y++;
      end else begin
        x++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: holds a stalled request, otherwise offers the next pixel or idles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && (!in_valid || !in_stall)) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_valid <= 1'b1;
        in_pixel <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall: random per phase, plus one long counted hold-off on request
  always @(posedge clk) begin
    if (!hold_req) begin
      hold_cnt <= 0;
    end else if (hold_cnt != HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
    end
    out_stall <= (hold_req && hold_cnt != HOLD_CYCLES) ||
                 ($urandom_range(99) < out_stall_pct);
  end

  // Monitor: predict on each accepted pixel, check each accepted gradient
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_gradient(in_pixel);
        pix_taken++;
      end
      if (out_valid && !out_stall) check_gradient();
    end
  end

  // Watchdog: nothing moving on any channel for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_pixel(input ig3_pkg::pix_t p);
    pixel_q.push_back(p);
    pix_sent++;
  endfunction

  // random texture per call: full random, saturated black/white, or a mix
  task automatic push_pixels(input int unsigned n);
    int unsigned   mode;
    ig3_pkg::pix_t p;
    mode = $urandom_range(2);
    repeat (n) begin
      case (mode)
        0:       p = ig3_pkg::pix_t'($urandom);
        1:       p = $urandom_range(1) ? '1 : '0;
        default: p = ($urandom_range(2) == 0) ? '1 :
                     ($urandom_range(1) ? ig3_pkg::pix_t'($urandom) : '0);
      endcase
      queue_pixel(p);
    end
  endtask

  // every pixel accepted and every gradient out, then let the pipe drain
  task automatic wait_idle();
    while (pix_taken != pix_sent || expected_grads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input ig3_pkg::cfg_reg_t idx,
                         input logic [ig3_pkg::CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ig3_pkg::REG_IMAGE_WIDTH:  width_reg  = val[ig3_pkg::IMG_W_W-1:0];
      ig3_pkg::REG_IMAGE_HEIGHT: height_reg = val[ig3_pkg::IMG_H_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ig3_pkg::CFG_DATA_W-1:0] pick_width();
    logic [ig3_pkg::CFG_DATA_W-1:0] v;
    case ($urandom_range(9))
      0:       v = ig3_pkg::CFG_DATA_W'($urandom_range(2));       // below minimum
      1, 2:    v = ig3_pkg::CFG_DATA_W'($urandom_range(OPEN_W, 11));
      default: v = ig3_pkg::CFG_DATA_W'($urandom_range(10, 3));
    endcase
    // bits above the width register are dropped by the block
    if ($urandom_range(3) == 0)
      v[ig3_pkg::CFG_DATA_W-1:ig3_pkg::IMG_W_W] =
        (ig3_pkg::CFG_DATA_W - ig3_pkg::IMG_W_W)'($urandom);
    return v;
  endfunction

  function automatic logic [ig3_pkg::CFG_DATA_W-1:0] pick_height();
    case ($urandom_range(9))
      0:       return ig3_pkg::CFG_DATA_W'($urandom_range(2));
      1:       return ig3_pkg::CFG_DATA_W'($urandom_range(12, 7));
      default: return ig3_pkg::CFG_DATA_W'($urandom_range(6, 3));
    endcase
  endfunction

  // New frame: maybe new size, then a whole frame or part of one.
  // Mid-frame: change one register, then the rest of the frame or part of it.
  // Widening mid-frame is safe: the opening frame, as wide as any random
  // width, defined every column of both line stores that can be read.
  task automatic run_segment();
    int unsigned rest;
    wait_idle();
    if (col_cnt == 0 && row_cnt == 0) begin
      if ($urandom_range(3) != 0) set_reg(ig3_pkg::REG_IMAGE_WIDTH, pick_width());
      if ($urandom_range(3) != 0) set_reg(ig3_pkg::REG_IMAGE_HEIGHT, pick_height());
    end else if ($urandom_range(1)) begin
      set_reg(ig3_pkg::REG_IMAGE_WIDTH, pick_width());
    end else begin
      set_reg(ig3_pkg::REG_IMAGE_HEIGHT, pick_height());
    end
    rest = frame_rest();
    if ($urandom_range(3) == 0 && rest > 1) rest = $urandom_range(rest - 1, 1);
    push_pixels(rest);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase_start;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Opening frame as wide as any random width: three full rows, then
    // shrink the height mid-frame so the fourth row closes the frame.
    // Also fills both line stores across every column used later.
    set_reg(ig3_pkg::REG_IMAGE_WIDTH, ig3_pkg::CFG_DATA_W'(OPEN_W));
    push_pixels(3 * OPEN_W);
    set_reg(ig3_pkg::REG_IMAGE_HEIGHT, 16'h0002);   // acts as 3, already past it
    push_pixels(frame_rest());

    // 4x3 frame, columns 0,0,max,0: largest positive then negative grad_x
    set_reg(ig3_pkg::REG_IMAGE_WIDTH, 16'h0004);
    set_reg(ig3_pkg::REG_IMAGE_HEIGHT, 16'h0000);
    for (int r = 0; r < 3; r++) begin
      queue_pixel('0);
      queue_pixel('0);
      queue_pixel('1);
      queue_pixel('0);
    end
    // 3x4 frame, rows 0,0,max,0: largest positive then negative grad_y
    set_reg(ig3_pkg::REG_IMAGE_WIDTH, 16'hF002);
    set_reg(ig3_pkg::REG_IMAGE_HEIGHT, 16'h0004);
    for (int r = 0; r < 4; r++) begin
      repeat (3) queue_pixel((r == 2) ? '1 : '0);
    end

    // Long output hold-off with the sender always offering: the block
    // has to fill up and push back on its input.
    set_reg(ig3_pkg::REG_IMAGE_WIDTH, 16'h0008);
    set_reg(ig3_pkg::REG_IMAGE_HEIGHT, 16'h000A);
    hold_req <= 1'b1;
    push_pixels(frame_rest());
    wait_idle();
    hold_req <= 1'b0;

    // Random frames under the four idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct <= 0;  out_stall_pct <= 0;  end
        1: begin in_idle_pct <= 60; out_stall_pct <= 0;  end
        2: begin in_idle_pct <= 0;  out_stall_pct <= 60; end
        default: begin in_idle_pct <= 25; out_stall_pct <= 25; end
      endcase
      phase_start = pix_sent;
      while (pix_sent - phase_start < RAND_PER_PHASE) run_segment();
    end

    // Close any open frame, then one narrow, taller frame
    wait_idle();
    in_idle_pct   <= 0;
    out_stall_pct <= 0;
    if (col_cnt != 0 || row_cnt != 0) push_pixels(frame_rest());
    set_reg(ig3_pkg::REG_IMAGE_WIDTH, 16'h0003);
    set_reg(ig3_pkg::REG_IMAGE_HEIGHT, 16'h0030);
    push_pixels(frame_rest());

    wait_idle();
    if (mismatches == 0 && expected_grads.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: image_gradient_3x3_unit.f
+incdir+hdl
hdl/ig3_pkg.sv
hdl/ig3_ram.sv
hdl/image_gradient_3x3_unit.sv
dv/tb_image_gradient_3x3_unit.sv
